// ----- rtl/stereo_chorus_delay_unit_defines.svh -----
// assertion macros shared by the stereo chorus checker
`ifndef STEREO_CHORUS_DELAY_UNIT_DEFINES_SVH
`define STEREO_CHORUS_DELAY_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is sampled asserted
`define SCD_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ----- rtl/scd_pkg.sv -----
// shared constants, types and the sine table builder for the stereo chorus
package scd_pkg;

  // sizes
  localparam int LINE_DEPTH    = 4096;
  localparam int LINE_BITS     = $clog2(LINE_DEPTH);
  localparam int SINE_ENTRIES  = 1024;
  localparam int SINE_BITS     = $clog2(SINE_ENTRIES);
  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = 32;
  localparam int SINE_W        = 16;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 31;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOD_DEPTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_BASE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_BASE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_GAIN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_GAIN  = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SINE_W-1:0]      sine_t;
  typedef sine_t sine_tab_t [SINE_ENTRIES];

  // one access to a delay line ram
  typedef struct packed {
    logic                 we;
    logic [LINE_BITS-1:0] waddr;
    sample_t              wdata;
    logic [LINE_BITS-1:0] raddr;
  } line_req_t;

  localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // one period of sine in Q1.15, Taylor series to x^9 in Q30
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [1:0]  quad;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      p    = {32'(i), 32'd0} / 64'(SINE_ENTRIES);
      quad = p[31:30];
      r    = {34'd0, p[29:0]};
      if (quad[0]) begin
        r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + 64'h2000_0000) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[i] = quad[1] ? SINE_W'(-v) : SINE_W'(v);
    end
    return tab;
  endfunction

endpackage

// ----- rtl/scd_ifs.sv -----
// stream interfaces for stereo sample pairs in and chorused pairs out
interface scd_in_if;
  import scd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scd_out_if;
  import scd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/scd_sine_rom.sv -----
// one-period sine rom with registered read
module scd_sine_rom (
  input  logic                         clk,
  input  logic [scd_pkg::SINE_BITS-1:0] addr,
  output scd_pkg::sine_t               data
);
  import scd_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine();

  sine_t data_r;

  // registered lookup
  always_ff @(posedge clk) begin
    data_r <= SINE_TAB[addr];
  end

  assign data = data_r;

endmodule

// ----- rtl/scd_line_ram.sv -----
// delay line storage: one write and one registered read per cycle
module scd_line_ram (
  input  logic               clk,
  input  scd_pkg::line_req_t req,
  output scd_pkg::sample_t   rd_data
);
  import scd_pkg::*;

  sample_t mem [LINE_DEPTH];
  sample_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/stereo_chorus_delay_unit.sv -----
// stereo chorus top level: sequencer, lfo, delay line access and output stage
// the eight-state sequencer takes one pair at a time through sine lookup, two line
//   reads, interpolation, gain and saturation; no new pair is accepted until the
//   result is loaded into the output register
// reset: settings return to defaults, lfo phase, write pointer and full flag clear;
//   the lines read as zero until written, so no clearing pass is needed
module stereo_chorus_delay_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  scd_in_if.sink                           in_ch,
  scd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [scd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [scd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import scd_pkg::*;

  localparam int PROD_BITS  = SINE_W + 17;
  localparam int IP_SHIFT   = 23;
  localparam int FRAC_SHIFT = 15;
  localparam int FRAC_BITS  = 8;
  localparam int Y_BITS     = SAMPLE_BITS + 10;
  localparam int ACC_BITS   = Y_BITS + 16;
  localparam int OUT_SHIFT  = 22;
  localparam int O_BITS     = ACC_BITS - OUT_SHIFT;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(64'd1 << (OUT_SHIFT - 1));
  localparam logic signed [O_BITS-1:0] SMAX = O_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [O_BITS-1:0] SMIN = -SMAX - O_BITS'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SINE = 8'b0000_0010,
    S_ADDR = 8'b0000_0100,
    S_RDA  = 8'b0000_1000,
    S_RDB  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_SAT  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [30:0] phase_step_r;
  logic [15:0] mod_depth_r;
  logic [11:0] base_l_r, base_r_r;
  logic [14:0] gain_l_r, gain_r_r;

  // lfo and pointer state
  logic [PHASE_BITS-1:0] phase_r;
  logic [LINE_BITS-1:0]  wp_r;
  logic                  full_r;

  // per-item datapath registers
  sample_t                    in_l_r, in_r_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic [FRAC_BITS-1:0]       frac_r;
  logic [LINE_BITS-1:0]       pos_l_r, pos_r_r;
  logic                       va_l_r, va_r_r, vb_l_r, vb_r_r;
  sample_t                    a_l_r, a_r_r;
  logic signed [Y_BITS-1:0]   y_l_r, y_r_r;
  logic signed [ACC_BITS-1:0] acc_l_r, acc_r_r;
  sample_t                    res_l_r, res_r_r;

  // output stage
  logic    out_valid_r;
  sample_t out_l_r, out_r_r;

  // memory interfaces
  sine_t     sine_q;
  line_req_t req_l, req_r;
  sample_t   rd_l, rd_r;

  // combinational datapath
  logic signed [PROD_BITS-1:0] prod_nxt;
  logic [LINE_BITS-1:0]        ip_ext;
  logic [LINE_BITS-1:0]        pos_l_nxt, pos_r_nxt;
  logic [LINE_BITS-1:0]        posb_l, posb_r;
  sample_t                     b_l, b_r;
  logic signed [SAMPLE_BITS:0] diff_l, diff_r;
  logic signed [Y_BITS-1:0]    y_l_nxt, y_r_nxt;
  logic signed [ACC_BITS-1:0]  acc_l_nxt, acc_r_nxt;
  logic signed [O_BITS-1:0]    o_l, o_r;
  sample_t                     sat_l, sat_r;
  logic                        in_acc, out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // memories
  scd_sine_rom u_sine (
    .clk  (clk),
    .addr (phase_r[PHASE_BITS-1 -: SINE_BITS]),
    .data (sine_q)
  );

  scd_line_ram u_line_l (
    .clk     (clk),
    .req     (req_l),
    .rd_data (rd_l)
  );

  scd_line_ram u_line_r (
    .clk     (clk),
    .req     (req_r),
    .rd_data (rd_r)
  );

  // offset from depth times sine, read positions
  always_comb begin
    prod_nxt  = PROD_BITS'($signed({1'b0, mod_depth_r})) * PROD_BITS'(sine_q);
    ip_ext    = LINE_BITS'(prod_r >>> IP_SHIFT);
    pos_l_nxt = wp_r - LINE_BITS'(base_l_r) + ip_ext;
    pos_r_nxt = wp_r - LINE_BITS'(base_r_r) + ip_ext;
    posb_l    = pos_l_r + LINE_BITS'(1);
    posb_r    = pos_r_r + LINE_BITS'(1);
  end

  // line ram requests: read a, then b, then write the input pair
  always_comb begin
    req_l.we    = (state_r == S_MUL);
    req_l.waddr = wp_r;
    req_l.wdata = in_l_r;
    req_l.raddr = (state_r == S_RDA) ? posb_l : pos_l_nxt;
    req_r.we    = (state_r == S_MUL);
    req_r.waddr = wp_r;
    req_r.wdata = in_r_r;
    req_r.raddr = (state_r == S_RDA) ? posb_r : pos_r_nxt;
  end

  // linear interpolation
  always_comb begin
    b_l     = vb_l_r ? rd_l : '0;
    b_r     = vb_r_r ? rd_r : '0;
    diff_l  = (SAMPLE_BITS + 1)'(b_l) - (SAMPLE_BITS + 1)'(a_l_r);
    diff_r  = (SAMPLE_BITS + 1)'(b_r) - (SAMPLE_BITS + 1)'(a_r_r);
    y_l_nxt = (Y_BITS'(a_l_r) <<< FRAC_BITS)
            + Y_BITS'(diff_l) * Y_BITS'($signed({1'b0, frac_r}));
    y_r_nxt = (Y_BITS'(a_r_r) <<< FRAC_BITS)
            + Y_BITS'(diff_r) * Y_BITS'($signed({1'b0, frac_r}));
  end

  // gain with rounding
  always_comb begin
    acc_l_nxt = ACC_BITS'(y_l_r) * ACC_BITS'($signed({1'b0, gain_l_r})) + ROUND_HALF;
    acc_r_nxt = ACC_BITS'(y_r_r) * ACC_BITS'($signed({1'b0, gain_r_r})) + ROUND_HALF;
  end

  // saturation
  always_comb begin
    o_l = O_BITS'(acc_l_r >>> OUT_SHIFT);
    o_r = O_BITS'(acc_r_r >>> OUT_SHIFT);
    if (o_l > SMAX) begin
      sat_l = SAMPLE_BITS'(SMAX);
    end else if (o_l < SMIN) begin
      sat_l = SAMPLE_BITS'(SMIN);
    end else begin
      sat_l = SAMPLE_BITS'(o_l);
    end
    if (o_r > SMAX) begin
      sat_r = SAMPLE_BITS'(SMAX);
    end else if (o_r < SMIN) begin
      sat_r = SAMPLE_BITS'(SMIN);
    end else begin
      sat_r = SAMPLE_BITS'(o_r);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SINE;
        end
      end
      S_SINE: state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MUL) begin
        phase_r <= phase_r + PHASE_BITS'(phase_step_r);
        wp_r    <= wp_r + LINE_BITS'(1);
        if (wp_r == LINE_BITS'(LINE_DEPTH - 1)) begin
          full_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      mod_depth_r  <= '0;
      base_l_r     <= 12'd64;
      base_r_r     <= 12'd64;
      gain_l_r     <= 15'd16384;
      gain_r_r     <= 15'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP: phase_step_r <= cfg_data[30:0];
        REG_MOD_DEPTH:  mod_depth_r  <= cfg_data[15:0];
        REG_LEFT_BASE:  base_l_r     <= cfg_data[11:0];
        REG_RIGHT_BASE: base_r_r     <= cfg_data[11:0];
        REG_LEFT_GAIN:  gain_l_r     <= cfg_data[14:0];
        REG_RIGHT_GAIN: gain_r_r     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // datapath registers; unwritten line entries read as zero
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_l_r <= in_ch.left_in;
      in_r_r <= in_ch.right_in;
    end
    if (state_r == S_SINE) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_ADDR) begin
      frac_r  <= prod_r[FRAC_SHIFT +: FRAC_BITS];
      pos_l_r <= pos_l_nxt;
      pos_r_r <= pos_r_nxt;
      va_l_r  <= full_r || (pos_l_nxt < wp_r);
      va_r_r  <= full_r || (pos_r_nxt < wp_r);
    end
    if (state_r == S_RDA) begin
      a_l_r  <= va_l_r ? rd_l : '0;
      a_r_r  <= va_r_r ? rd_r : '0;
      vb_l_r <= full_r || (posb_l < wp_r);
      vb_r_r <= full_r || (posb_r < wp_r);
    end
    if (state_r == S_RDB) begin
      y_l_r <= y_l_nxt;
      y_r_r <= y_r_nxt;
    end
    if (state_r == S_MUL) begin
      acc_l_r <= acc_l_nxt;
      acc_r_r <= acc_r_nxt;
    end
    if (state_r == S_SAT) begin
      res_l_r <= sat_l;
      res_r_r <= sat_r;
    end
    if (out_load) begin
      out_l_r <= res_l_r;
      out_r_r <= res_r_r;
    end
  end

  // ports
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_l_r;
  assign out_ch.right_out = out_r_r;

endmodule

// ----- rtl/scd_checker.sv -----
// port-level checker for the stereo chorus and its bind to the top level
`include "stereo_chorus_delay_unit_defines.svh"

module scd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input scd_pkg::sample_t out_left,
  input scd_pkg::sample_t out_right
);
  import scd_pkg::*;

  // a stalled result holds
  `SCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right), "stalled result changed")

  // one transaction in flight: no accept right after an accept
  `SCD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input accepted while busy")

  // a result cannot appear the cycle after its input
  `SCD_ASSERT_NOW(a_min_latency, $rose(out_valid), !$past(in_valid && in_ready), "result too early")

  // reset empties the output and opens the input
  `SCD_ASSERT_RESET(a_reset_state, !out_valid && in_ready, "bad state after reset")

endmodule

bind stereo_chorus_delay_unit scd_checker u_scd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_out),
  .out_right (out_ch.right_out)
);
